// ----- sv/qtsg_pkg.sv -----
package qtsg_pkg;

  // field and datapath widths
  localparam int CoordW = 32;
  localparam int BaryW  = 16;
  localparam int GradW  = 40;
  localparam int StoreW = 48;
  localparam int CofW   = 68;
  localparam int AccW   = 104;
  localparam int DenW   = 103;
  localparam int MulW   = 33;
  localparam int ProdW  = 2 * MulW;

  // function codes of an input item
  localparam logic FuncLoad = 1'b0;
  localparam logic FuncEval = 1'b1;

  typedef struct packed {
    logic                     func;
    logic [1:0]               vertex_index;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic signed [BaryW-1:0]  bary_b;
    logic signed [BaryW-1:0]  bary_c;
    logic signed [BaryW-1:0]  bary_d;
  } in_t;

  typedef struct packed {
    logic [3:0]              node_number;
    logic signed [GradW-1:0] grad_x;
    logic signed [GradW-1:0] grad_y;
    logic signed [GradW-1:0] grad_z;
    logic                    degenerate;
    logic                    last;
  } out_t;

  // request to and response from the divider
  typedef struct packed {
    logic                   start;
    logic signed [CofW-1:0] num;
    logic [DenW-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [StoreW-1:0] quo;
  } div_rsp_t;

endpackage

// ----- sv/qtsg_mul.sv -----
module qtsg_mul (
  input  logic                             clk_i,
  input  logic signed [qtsg_pkg::MulW-1:0]  a_i,
  input  logic signed [qtsg_pkg::MulW-1:0]  b_i,
  output logic signed [qtsg_pkg::ProdW-1:0] p_o
);
  import qtsg_pkg::*;

  logic signed [ProdW-1:0] p_q;

  // registered signed product
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ----- sv/qtsg_div.sv -----
module qtsg_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qtsg_pkg::div_req_t  req_i,
  output qtsg_pkg::div_rsp_t  rsp_o
);
  import qtsg_pkg::*;

  localparam int LowBits = 16;
  localparam int ZeroBits = 32;
  localparam int ShW = DenW + LowBits;
  localparam int QW = StoreW + 1;
  localparam logic [QW-1:0] LimPos = {2'b00, {(StoreW-1){1'b1}}};
  localparam logic [QW-1:0] LimNeg = {2'b01, {(StoreW-1){1'b0}}};

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_FIN  = 3'b100
  } dstate_e;

  dstate_e           st_q, st_d;
  logic              done_q, done_d;
  logic              neg_q, neg_d;
  logic [DenW-1:0]   rem_q, rem_d;
  logic [DenW-1:0]   den_q, den_d;
  logic [StoreW-1:0] bits_q, bits_d;
  logic [StoreW-1:0] quo_q, quo_d;
  logic [StoreW-1:0] res_q, res_d;
  logic [5:0]        cnt_q, cnt_d;

  logic [CofW-1:0]   mag;
  logic [ShW-1:0]    mag_w, den_sh;
  logic              over;
  logic [DenW:0]     trial, den_x;
  logic              rnd;
  logic [QW-1:0]     q_r, q_s, q_n;

  // one quotient bit per cycle, restoring form
  always_comb begin
    st_d   = st_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    rem_d  = rem_q;
    den_d  = den_q;
    bits_d = bits_q;
    quo_d  = quo_q;
    res_d  = res_q;
    cnt_d  = cnt_q;

    mag    = req_i.num[CofW-1] ? CofW'(-req_i.num) : CofW'(req_i.num);
    mag_w  = ShW'(mag);
    den_sh = {req_i.den, {LowBits{1'b0}}};
    over   = mag_w >= den_sh;
    trial  = {rem_q, bits_q[StoreW-1]};
    den_x  = {1'b0, den_q};
    rnd    = {rem_q, 1'b0} >= den_x;
    q_r    = {1'b0, quo_q} + QW'(rnd);
    q_s    = q_r;
    if (neg_q) begin
      if (q_r > LimNeg) q_s = LimNeg;
    end else begin
      if (q_r > LimPos) q_s = LimPos;
    end
    q_n    = -q_s;

    unique case (st_q)
      D_IDLE: begin
        if (req_i.start) begin
          neg_d = req_i.num[CofW-1];
          den_d = req_i.den;
          if (over) begin
            // quotient does not fit, clamp at once
            res_d  = req_i.num[CofW-1] ? LimNeg[StoreW-1:0] : LimPos[StoreW-1:0];
            done_d = 1'b1;
          end else begin
            rem_d  = DenW'(mag[CofW-1:LowBits]);
            bits_d = {mag[LowBits-1:0], {ZeroBits{1'b0}}};
            quo_d  = '0;
            cnt_d  = '0;
            st_d   = D_RUN;
          end
        end
      end
      D_RUN: begin
        if (trial >= den_x) begin
          rem_d = DenW'(trial - den_x);
          quo_d = {quo_q[StoreW-2:0], 1'b1};
        end else begin
          rem_d = trial[DenW-1:0];
          quo_d = {quo_q[StoreW-2:0], 1'b0};
        end
        bits_d = {bits_q[StoreW-2:0], 1'b0};
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == 6'(StoreW - 1)) st_d = D_FIN;
      end
      D_FIN: begin
        // round half away from zero, saturate, restore sign
        res_d  = neg_q ? q_n[StoreW-1:0] : q_s[StoreW-1:0];
        done_d = 1'b1;
        st_d   = D_IDLE;
      end
      default: st_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= D_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    bits_q <= bits_d;
    quo_q  <= quo_d;
    res_q  <= res_d;
    cnt_q  <= cnt_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = res_q;

endmodule

// ----- sv/quadratic_tet_shape_gradients.sv -----
// Load item: accepted while idle, no result; the next evaluation recomputes.
// Evaluation with current gradients: ten results, each partial product read,
// multiplied and accumulated on the one shared 33x33 multiplier.
// First evaluation after a load computes twelve cofactors and the determinant,
// then, unless the element is flat, twelve divisions in the divider.
// Reset clears the corner store and marks the gradients stale.
module quadratic_tet_shape_gradients (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  qtsg_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output qtsg_pkg::out_t out_data_o
);
  import qtsg_pkg::*;

  localparam int LamW = 18;
  localparam int WgtW = 20;
  localparam logic signed [LamW-1:0] OneQ14 = 18'sd16384;
  localparam logic signed [WgtW-1:0] OneQ14W = 20'sd16384;
  localparam logic signed [AccW-1:0] RoundHalf = 104'sd8192;
  localparam int RoundShift = 14;

  // shift codes of a partial product
  localparam logic [1:0] ShNone = 2'd0;
  localparam logic [1:0] Sh32   = 2'd1;
  localparam logic [1:0] Sh64   = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RDA  = 7'b0000010,
    S_RDB  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_ACC  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  typedef enum logic [2:0] {
    M_COF  = 3'b001,
    M_DET  = 3'b010,
    M_EVAL = 3'b100
  } mode_e;

  typedef struct packed {
    logic [1:0] a_s;
    logic [1:0] b_s;
    logic       neg;
  } cof_term_t;

  // s-th corner in ascending order leaving out corner i
  function automatic logic [1:0] other_vert(input logic [1:0] i, input logic [1:0] s);
    logic [1:0] v;
    v = (s >= i) ? s + 2'd1 : s;
    return v;
  endfunction

  // the six products of a 3x3 minor of rows [1 p q]
  function automatic cof_term_t cof_term(input logic [2:0] t);
    cof_term_t r;
    unique case (t)
      3'd0:    r = '{a_s: 2'd1, b_s: 2'd2, neg: 1'b0};
      3'd1:    r = '{a_s: 2'd2, b_s: 2'd1, neg: 1'b1};
      3'd2:    r = '{a_s: 2'd0, b_s: 2'd2, neg: 1'b1};
      3'd3:    r = '{a_s: 2'd2, b_s: 2'd0, neg: 1'b0};
      3'd4:    r = '{a_s: 2'd0, b_s: 2'd1, neg: 1'b0};
      3'd5:    r = '{a_s: 2'd1, b_s: 2'd0, neg: 1'b1};
      default: r = '{a_s: 2'd0, b_s: 2'd0, neg: 1'b0};
    endcase
    return r;
  endfunction

  // corners of edges 01, 12, 20, 03, 13, 23
  function automatic logic [3:0] edge_pair(input logic [2:0] e);
    logic [3:0] r;
    unique case (e)
      3'd0:    r = {2'd0, 2'd1};
      3'd1:    r = {2'd1, 2'd2};
      3'd2:    r = {2'd2, 2'd0};
      3'd3:    r = {2'd0, 2'd3};
      3'd4:    r = {2'd1, 2'd3};
      3'd5:    r = {2'd2, 2'd3};
      default: r = {2'd0, 2'd0};
    endcase
    return r;
  endfunction

  // q.30 sum to q24.16: round half up, saturate
  function automatic logic signed [GradW-1:0] finish(input logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] v;
    logic signed [GradW-1:0] r;
    v = (a + RoundHalf) >>> RoundShift;
    if ((&v[AccW-1:GradW-1]) || !(|v[AccW-1:GradW-1])) begin
      r = v[GradW-1:0];
    end else if (v[AccW-1]) begin
      r = {1'b1, {(GradW-1){1'b0}}};
    end else begin
      r = {1'b0, {(GradW-1){1'b1}}};
    end
    return r;
  endfunction

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  logic [3:0] job_q, job_d;
  logic [2:0] term_q, term_d;
  logic [1:0] axis_q, axis_d;
  logic [3:0] node_q, node_d;
  logic       current_q, current_d;
  logic       degen_q, degen_d;
  logic       out_valid_q, out_valid_d;
  logic       div_go_q, div_go_d;

  logic signed [CoordW-1:0] vtx_q [4][3];
  logic signed [CofW-1:0]   cof_q [12];
  logic [StoreW-1:0]        grad_q [12];
  logic signed [LamW-1:0]   lam_q [4];
  logic signed [GradW-1:0]  res_q [3];

  logic signed [MulW-1:0]  a_q, a_d, b_q, b_d;
  logic [1:0]              sh_q, sh_d;
  logic                    neg_q, neg_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic [DenW-1:0]         den_q, den_d;
  out_t                    out_q;

  logic vtx_we, lam_we, cof_we, grad_we, res_we, out_load;

  logic in_acc, out_free;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  prod_ext, shifted, acc_sum, acc_abs;

  logic [1:0] k_c, i_c, pax, qax, vrd_v, vrd_k;
  cof_term_t  tsel;
  logic signed [CoordW-1:0] vrd;
  logic signed [CofW-1:0]   crd;

  logic       is_edge;
  logic [3:0] node_off;
  logic [3:0] pair;
  logic [1:0] wn, gn;
  logic signed [LamW-1:0] wl;
  logic signed [WgtW-1:0] w4, wv;
  logic [StoreW-1:0]      g;
  logic [2:0]             last_t;

  logic signed [MulW-1:0] op_a, op_b;
  logic [1:0]             op_sh;
  logic                   op_neg;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // shared multiplier and divider
  qtsg_mul u_mul (
    .clk_i (clk_i),
    .a_i   (a_q),
    .b_i   (b_q),
    .p_o   (prod)
  );

  assign div_req.start = div_go_q;
  assign div_req.num   = crd;
  assign div_req.den   = den_q;

  qtsg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // operand selection for the next partial product
  always_comb begin
    k_c  = job_q[3:2];
    i_c  = job_q[1:0];
    tsel = cof_term(term_q);
    pax  = (k_c == 2'd0) ? 2'd1 : 2'd0;
    qax  = (k_c == 2'd2) ? 2'd1 : 2'd2;
    vrd_v = 2'd0;
    vrd_k = 2'd0;
    if (mode_q == M_COF) begin
      if (state_q == S_RDB) begin
        vrd_v = other_vert(i_c, tsel.b_s);
        vrd_k = qax;
      end else begin
        vrd_v = other_vert(i_c, tsel.a_s);
        vrd_k = pax;
      end
    end else if (mode_q == M_DET) begin
      vrd_v = job_q[1:0];
    end
    vrd = vtx_q[vrd_v][vrd_k];
    crd = cof_q[job_q];

    // evaluation weights and stored gradient
    is_edge  = node_q >= 4'd4;
    node_off = node_q - 4'd4;
    pair     = edge_pair(node_off[2:0]);
    if (!is_edge) begin
      wn = node_q[1:0];
      gn = node_q[1:0];
    end else if (!term_q[1]) begin
      wn = pair[1:0];
      gn = pair[3:2];
    end else begin
      wn = pair[3:2];
      gn = pair[1:0];
    end
    wl     = lam_q[wn];
    w4     = {wl, 2'b00};
    wv     = is_edge ? w4 : w4 - OneQ14W;
    g      = degen_q ? '0 : grad_q[{axis_q, gn}];
    last_t = is_edge ? 3'd3 : 3'd1;

    op_a   = MulW'(vrd);
    op_b   = MulW'(vrd);
    op_sh  = ShNone;
    op_neg = 1'b0;
    unique case (mode_q)
      M_COF: begin
        op_neg = tsel.neg ^ ~(i_c[0] ^ k_c[0]);
      end
      M_DET: begin
        op_sh = term_q[1:0];
        unique case (term_q[1:0])
          2'd0:    op_b = {1'b0, crd[31:0]};
          2'd1:    op_b = {1'b0, crd[63:32]};
          default: op_b = MulW'($signed(crd[CofW-1:64]));
        endcase
      end
      M_EVAL: begin
        op_a = MulW'(wv);
        if (term_q[0]) begin
          op_b  = MulW'($signed(g[StoreW-1:32]));
          op_sh = Sh32;
        end else begin
          op_b  = {1'b0, g[31:0]};
        end
      end
      default: op_neg = 1'b0;
    endcase
  end

  // accumulate the registered product
  always_comb begin
    prod_ext = AccW'(prod);
    unique case (sh_q)
      Sh32:    shifted = prod_ext <<< 32;
      Sh64:    shifted = prod_ext <<< 64;
      default: shifted = prod_ext;
    endcase
    acc_sum = neg_q ? acc_q - shifted : acc_q + shifted;
    acc_abs = acc_sum[AccW-1] ? -acc_sum : acc_sum;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    job_d       = job_q;
    term_d      = term_q;
    axis_d      = axis_q;
    node_d      = node_q;
    current_d   = current_q;
    degen_d     = degen_q;
    div_go_d    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    acc_d       = acc_q;
    den_d       = den_q;
    a_d         = a_q;
    b_d         = b_q;
    sh_d        = sh_q;
    neg_d       = neg_q;
    vtx_we      = 1'b0;
    lam_we      = 1'b0;
    cof_we      = 1'b0;
    grad_we     = 1'b0;
    res_we      = 1'b0;
    out_load    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.func == FuncLoad) begin
            vtx_we    = 1'b1;
            current_d = 1'b0;
          end else begin
            lam_we  = 1'b1;
            job_d   = '0;
            term_d  = '0;
            axis_d  = '0;
            node_d  = '0;
            acc_d   = '0;
            mode_d  = current_q ? M_EVAL : M_COF;
            state_d = S_RDA;
          end
        end
      end
      S_RDA: begin
        a_d   = op_a;
        sh_d  = op_sh;
        neg_d = op_neg;
        if (mode_q == M_COF) begin
          state_d = S_RDB;
        end else begin
          b_d     = op_b;
          state_d = S_MUL;
        end
      end
      S_RDB: begin
        b_d     = op_b;
        state_d = S_MUL;
      end
      S_MUL: state_d = S_ACC;
      S_ACC: begin
        state_d = S_RDA;
        unique case (mode_q)
          M_COF: begin
            if (term_q == 3'd5) begin
              cof_we = 1'b1;
              acc_d  = '0;
              term_d = '0;
              if (job_q == 4'd11) begin
                mode_d = M_DET;
                job_d  = '0;
              end else begin
                job_d = job_q + 4'd1;
              end
            end else begin
              acc_d  = acc_sum;
              term_d = term_q + 3'd1;
            end
          end
          M_DET: begin
            acc_d = acc_sum;
            if (term_q == 3'd2) begin
              term_d = '0;
              if (job_q == 4'd3) begin
                job_d = '0;
                if (acc_sum == '0) begin
                  // flat element: zero gradients from here on
                  degen_d   = 1'b1;
                  current_d = 1'b1;
                  mode_d    = M_EVAL;
                  node_d    = '0;
                  axis_d    = '0;
                  acc_d     = '0;
                end else begin
                  degen_d  = 1'b0;
                  den_d    = acc_abs[DenW-1:0];
                  div_go_d = 1'b1;
                  state_d  = S_DIV;
                end
              end else begin
                job_d = job_q + 4'd1;
              end
            end else begin
              term_d = term_q + 3'd1;
            end
          end
          M_EVAL: begin
            if (term_q == last_t) begin
              res_we = 1'b1;
              acc_d  = '0;
              term_d = '0;
              if (axis_q == 2'd2) begin
                axis_d  = '0;
                state_d = S_EMIT;
              end else begin
                axis_d = axis_q + 2'd1;
              end
            end else begin
              acc_d  = acc_sum;
              term_d = term_q + 3'd1;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          grad_we = 1'b1;
          if (job_q == 4'd11) begin
            current_d = 1'b1;
            mode_d    = M_EVAL;
            node_d    = '0;
            axis_d    = '0;
            term_d    = '0;
            acc_d     = '0;
            state_d   = S_RDA;
          end else begin
            job_d    = job_q + 4'd1;
            div_go_d = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (node_q == 4'd9) begin
            state_d = S_IDLE;
          end else begin
            node_d  = node_q + 4'd1;
            term_d  = '0;
            state_d = S_RDA;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state and corner store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= M_COF;
      job_q       <= '0;
      term_q      <= '0;
      axis_q      <= '0;
      node_q      <= '0;
      current_q   <= 1'b0;
      degen_q     <= 1'b0;
      out_valid_q <= 1'b0;
      div_go_q    <= 1'b0;
      for (int v = 0; v < 4; v++) begin
        for (int k = 0; k < 3; k++) begin
          vtx_q[v][k] <= '0;
        end
      end
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      job_q       <= job_d;
      term_q      <= term_d;
      axis_q      <= axis_d;
      node_q      <= node_d;
      current_q   <= current_d;
      degen_q     <= degen_d;
      out_valid_q <= out_valid_d;
      div_go_q    <= div_go_d;
      if (vtx_we) begin
        vtx_q[in_data_i.vertex_index][0] <= in_data_i.coord_x;
        vtx_q[in_data_i.vertex_index][1] <= in_data_i.coord_y;
        vtx_q[in_data_i.vertex_index][2] <= in_data_i.coord_z;
      end
    end
  end

  // datapath registers and stores
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    sh_q  <= sh_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
    den_q <= den_d;
    if (lam_we) begin
      lam_q[1] <= LamW'(in_data_i.bary_b);
      lam_q[2] <= LamW'(in_data_i.bary_c);
      lam_q[3] <= LamW'(in_data_i.bary_d);
      lam_q[0] <= OneQ14 - LamW'(in_data_i.bary_b) - LamW'(in_data_i.bary_c)
                  - LamW'(in_data_i.bary_d);
    end
    if (cof_we) cof_q[job_q] <= acc_sum[CofW-1:0];
    if (grad_we) grad_q[job_q] <= div_rsp.quo;
    if (res_we) res_q[axis_q] <= finish(acc_sum);
    if (out_load) begin
      out_q.node_number <= node_q;
      out_q.grad_x      <= res_q[0];
      out_q.grad_y      <= res_q[1];
      out_q.grad_z      <= res_q[2];
      out_q.degenerate  <= degen_q;
      out_q.last        <= (node_q == 4'd9);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_last_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (out_data_o.node_number == 4'd9)))
    else $error("last flag does not match node number");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.degenerate) |->
      (out_data_o.grad_x == '0 && out_data_o.grad_y == '0 && out_data_o.grad_z == '0))
    else $error("flat element gave nonzero gradient");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("divider finished outside division phase");

  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_go_q |-> (state_q == S_DIV && den_q != '0))
    else $error("division started with zero determinant");

  a_node_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_o && out_data_o.node_number <= 4'd9))
    else $error("result node out of range");

endmodule
